// File: design/rk4c_pkg.sv
// rk4c_pkg: shared types, widths and stage codes of the rk4 stage combiner
// no dependencies; every other file of the block refers to it by scoped names

package rk4c_pkg;

    // variable store
    localparam int NUM_VARS = 64;
    localparam int VAR_W    = 6;
    localparam int ADDR_W   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    // item fields
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int STEP_W = 31;
    localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

    // stage codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HALF_A = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HALF_B = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FULL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINAL  = 3'd4;

    // datapath widths
    localparam int FRAC_W  = 16;
    localparam int H_HI_W  = STEP_W - FRAC_W;
    localparam int OP_W    = 35;
    localparam int PHI_W   = OP_W + H_HI_W + 1;
    localparam int PLO_W   = OP_W + FRAC_W + 1;
    localparam int SCL_W   = PLO_W + 1;
    localparam int CLAMP_W = 36;
    localparam int RES_W   = CLAMP_W + 2;

    // beyond six times 2^32 every stage saturates, so the scaled value is clipped there
    localparam logic signed [CLAMP_W-1:0] CLAMP_LIM = 36'sd25769803776;
    localparam logic signed [CLAMP_W-1:0] CLAMP_NEG = -36'sd25769803776;

    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

    // divide by six, one byte of dividend per stage
    localparam int DIV_W      = 40;
    localparam int DIV_BITS   = 8;
    localparam int DIV_STAGES = DIV_W / DIV_BITS;
    localparam int REM_W      = 3;
    localparam logic [REM_W-1:0] DIV_BY = 3'd6;
    localparam logic signed [CLAMP_W:0] DIV_BIAS = 37'sd5;
    localparam logic [DIV_W-1:0] DIV_MAX = 40'd25769803781;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [VAR_W-1:0]         var_index;
        logic signed [DATA_W-1:0] value_in;
        logic signed [DATA_W-1:0] derivative;
    } in_item_t;

    typedef struct packed {
        logic [VAR_W-1:0]         var_out;
        logic signed [DATA_W-1:0] new_value;
        logic                     step_done;
    } out_item_t;

    // what travels with an item down the back pipeline
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [VAR_W-1:0]         var_index;
        logic signed [DATA_W-1:0] start;
    } meta_t;

    typedef struct packed {
        meta_t                     meta;
        logic                      neg;
        logic signed [CLAMP_W-1:0] delta_pre;
    } div_tag_t;

endpackage

// File: design/rk4c_front.sv
// rk4c_front: input register that accepts items and drops illegal stages
// depends on rk4c_pkg

module rk4c_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rk4c_pkg::in_item_t   s_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rk4c_pkg::in_item_t   push_item
);

    logic                 f_valid_reg;
    logic                 f_keep_reg;
    rk4c_pkg::in_item_t   f_item_reg;
    logic                 legal;
    logic                 f_take;

    assign legal = (s_data.cmd <= rk4c_pkg::CMD_FINAL) &&
                   ({1'b0, s_data.var_index} < (rk4c_pkg::VAR_W + 1)'(rk4c_pkg::NUM_VARS));

    // a dropped item leaves without touching the queue
    assign f_take     = f_valid_reg && (!f_keep_reg || push_ready);
    assign s_ready    = !f_valid_reg || f_take;
    assign push_valid = f_valid_reg && f_keep_reg;
    assign push_item  = f_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f_item_reg <= s_data;
            f_keep_reg <= legal;
        end
    end

endmodule

// File: design/rk4c_fifo.sv
// rk4c_fifo: short queue of classified items between front and back
// depends on rk4c_pkg

module rk4c_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  rk4c_pkg::in_item_t   push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output rk4c_pkg::in_item_t   pop_item
);

    rk4c_pkg::in_item_t            entry_reg [rk4c_pkg::QDEPTH];
    logic [rk4c_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rk4c_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rk4c_pkg::QCNT_W-1:0]   count_reg;
    logic [rk4c_pkg::QCNT_W-1:0]   count_next;
    logic                          push;
    logic                          pop;

    assign push_ready = (count_reg != rk4c_pkg::QCNT_W'(rk4c_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/rk4c_div6.sv
// rk4c_div6: pipelined unsigned divide by six, one dividend byte per stage
// depends on rk4c_pkg; quotient bits replace dividend bits as the word moves down

module rk4c_div6 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [rk4c_pkg::DIV_W-1:0]     in_word,
    input  rk4c_pkg::div_tag_t             in_tag,
    output logic                           out_valid,
    output logic [rk4c_pkg::DIV_W-1:0]     out_word,
    output rk4c_pkg::div_tag_t             out_tag
);

    logic [rk4c_pkg::DIV_W-1:0]  word_reg  [rk4c_pkg::DIV_STAGES];
    logic [rk4c_pkg::REM_W-1:0]  rem_reg   [rk4c_pkg::DIV_STAGES-1];
    rk4c_pkg::div_tag_t          tag_reg   [rk4c_pkg::DIV_STAGES];
    logic                        valid_reg [rk4c_pkg::DIV_STAGES];

    logic [rk4c_pkg::DIV_W-1:0]  word_in   [rk4c_pkg::DIV_STAGES];
    logic [rk4c_pkg::REM_W-1:0]  rem_in    [rk4c_pkg::DIV_STAGES];
    logic [rk4c_pkg::DIV_W-1:0]  word_next [rk4c_pkg::DIV_STAGES];
    logic [rk4c_pkg::REM_W-1:0]  rem_next  [rk4c_pkg::DIV_STAGES];

    // restoring division of one byte, remainder stays below six
    function automatic logic [rk4c_pkg::REM_W+rk4c_pkg::DIV_BITS-1:0] div_chunk(
        input logic [rk4c_pkg::REM_W-1:0]    rem_start,
        input logic [rk4c_pkg::DIV_BITS-1:0] bits_in
    );
        logic [rk4c_pkg::REM_W-1:0]    rem;
        logic [rk4c_pkg::REM_W:0]      trial;
        logic [rk4c_pkg::DIV_BITS-1:0] q;
        rem = rem_start;
        q   = '0;
        for (int b = rk4c_pkg::DIV_BITS - 1; b >= 0; b--) begin
            trial = {rem, bits_in[b]};
            if (trial >= {1'b0, rk4c_pkg::DIV_BY}) begin
                q[b]  = 1'b1;
                trial = trial - {1'b0, rk4c_pkg::DIV_BY};
            end
            rem = trial[rk4c_pkg::REM_W-1:0];
        end
        return {rem, q};
    endfunction

    always_comb begin
        logic [rk4c_pkg::REM_W+rk4c_pkg::DIV_BITS-1:0] chunk;
        word_in[0] = in_word;
        rem_in[0]  = '0;
        for (int j = 1; j < rk4c_pkg::DIV_STAGES; j++) begin
            word_in[j] = word_reg[j-1];
            rem_in[j]  = rem_reg[j-1];
        end
        for (int j = 0; j < rk4c_pkg::DIV_STAGES; j++) begin
            chunk = div_chunk(rem_in[j],
                word_in[j][rk4c_pkg::DIV_W-1-rk4c_pkg::DIV_BITS*j -: rk4c_pkg::DIV_BITS]);
            word_next[j] = word_in[j];
            word_next[j][rk4c_pkg::DIV_W-1-rk4c_pkg::DIV_BITS*j -: rk4c_pkg::DIV_BITS] =
                chunk[rk4c_pkg::DIV_BITS-1:0];
            rem_next[j] = chunk[rk4c_pkg::REM_W+rk4c_pkg::DIV_BITS-1:rk4c_pkg::DIV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < rk4c_pkg::DIV_STAGES; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int j = 1; j < rk4c_pkg::DIV_STAGES; j++) begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int j = 1; j < rk4c_pkg::DIV_STAGES; j++) begin
                tag_reg[j] <= tag_reg[j-1];
            end
            for (int j = 0; j < rk4c_pkg::DIV_STAGES; j++) begin
                word_reg[j] <= word_next[j];
            end
            for (int j = 0; j < rk4c_pkg::DIV_STAGES - 1; j++) begin
                rem_reg[j] <= rem_next[j];
            end
        end
    end

    assign out_valid = valid_reg[rk4c_pkg::DIV_STAGES-1];
    assign out_word  = word_reg[rk4c_pkg::DIV_STAGES-1];
    assign out_tag   = tag_reg[rk4c_pkg::DIV_STAGES-1];

endmodule

// File: design/rk4c_back.sv
// rk4c_back: variable stores, slope combine, step multiply, divide and saturate
// depends on rk4c_pkg and rk4c_div6

module rk4c_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rk4c_pkg::STEP_W-1:0]     step_size,
    input  logic                            head_valid,
    output logic                            head_ready,
    input  rk4c_pkg::in_item_t              head,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rk4c_pkg::out_item_t             m_data
);

    logic                                en;
    logic                                pop;
    logic [rk4c_pkg::ADDR_W-1:0]         addr;

    logic signed [rk4c_pkg::DATA_W-1:0]  start_mem [rk4c_pkg::NUM_VARS];
    logic signed [rk4c_pkg::DATA_W-1:0]  one_mem   [rk4c_pkg::NUM_VARS];
    logic signed [rk4c_pkg::DATA_W-1:0]  two_mem   [rk4c_pkg::NUM_VARS];
    logic signed [rk4c_pkg::DATA_W-1:0]  three_mem [rk4c_pkg::NUM_VARS];
    logic signed [rk4c_pkg::DATA_W-1:0]  start_rd_reg;
    logic signed [rk4c_pkg::DATA_W-1:0]  one_rd_reg;
    logic signed [rk4c_pkg::DATA_W-1:0]  two_rd_reg;
    logic signed [rk4c_pkg::DATA_W-1:0]  three_rd_reg;

    logic                                p1_valid_reg;
    rk4c_pkg::meta_t                     p1_meta_reg;
    logic signed [rk4c_pkg::DATA_W-1:0]  p1_k_reg;

    logic signed [rk4c_pkg::OP_W-1:0]    k_ext;
    logic signed [rk4c_pkg::OP_W-1:0]    slope_sum;
    logic signed [rk4c_pkg::OP_W-1:0]    op_next;
    rk4c_pkg::meta_t                     p2_meta_next;
    logic                                p2_valid_reg;
    rk4c_pkg::meta_t                     p2_meta_reg;
    logic signed [rk4c_pkg::OP_W-1:0]    op_reg;

    logic signed [rk4c_pkg::H_HI_W:0]    hhi_s;
    logic signed [rk4c_pkg::FRAC_W:0]    hlo_s;
    logic signed [rk4c_pkg::PHI_W-1:0]   phi_next;
    logic signed [rk4c_pkg::PLO_W-1:0]   plo_next;
    logic                                p3_valid_reg;
    rk4c_pkg::meta_t                     p3_meta_reg;
    logic signed [rk4c_pkg::PHI_W-1:0]   phi_reg;
    logic signed [rk4c_pkg::PLO_W-1:0]   plo_reg;

    logic signed [rk4c_pkg::SCL_W-1:0]   scaled;
    logic signed [rk4c_pkg::CLAMP_W-1:0] c_next;
    logic                                p4_valid_reg;
    rk4c_pkg::meta_t                     p4_meta_reg;
    logic signed [rk4c_pkg::CLAMP_W-1:0] c_reg;

    logic signed [rk4c_pkg::CLAMP_W:0]   c_wide;
    logic signed [rk4c_pkg::CLAMP_W:0]   mag;
    rk4c_pkg::div_tag_t                  div_tag_next;
    logic                                p5_valid_reg;
    rk4c_pkg::div_tag_t                  div_tag_reg;
    logic [rk4c_pkg::DIV_W-1:0]          div_word_reg;

    logic                                q_valid;
    logic [rk4c_pkg::DIV_W-1:0]          q_word;
    rk4c_pkg::div_tag_t                  q_tag;
    logic signed [rk4c_pkg::CLAMP_W:0]   q_s;
    logic signed [rk4c_pkg::RES_W-1:0]   start_x;
    logic signed [rk4c_pkg::RES_W-1:0]   fin_sum;
    logic signed [rk4c_pkg::RES_W-1:0]   pre_sum;
    logic signed [rk4c_pkg::RES_W-1:0]   total;
    logic signed [rk4c_pkg::DATA_W-1:0]  sat_value;

    logic                                out_valid_reg;
    rk4c_pkg::out_item_t                 out_data_reg;

    // the whole back pipeline moves together behind the output register
    assign en         = !out_valid_reg || m_ready;
    assign head_ready = en;
    assign pop        = head_valid && en;
    assign addr       = head.var_index[rk4c_pkg::ADDR_W-1:0];

    // stores are written at issue, so a later item always reads the update
    always_ff @(posedge aclk) begin
        if (pop && (head.cmd == rk4c_pkg::CMD_LOAD)) begin
            start_mem[addr] <= head.value_in;
        end
        if (en) begin
            start_rd_reg <= start_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (head.cmd == rk4c_pkg::CMD_HALF_A)) begin
            one_mem[addr] <= head.derivative;
        end
        if (en) begin
            one_rd_reg <= one_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (head.cmd == rk4c_pkg::CMD_HALF_B)) begin
            two_mem[addr] <= head.derivative;
        end
        if (en) begin
            two_rd_reg <= two_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (head.cmd == rk4c_pkg::CMD_FULL)) begin
            three_mem[addr] <= head.derivative;
        end
        if (en) begin
            three_rd_reg <= three_mem[addr];
        end
    end

    // slope operand: k alone, or k1 + 2k2 + 2k3 + k4 for the final stage
    assign k_ext     = rk4c_pkg::OP_W'(p1_k_reg);
    assign slope_sum = rk4c_pkg::OP_W'(one_rd_reg) + (rk4c_pkg::OP_W'(two_rd_reg) <<< 1)
                     + (rk4c_pkg::OP_W'(three_rd_reg) <<< 1) + k_ext;

    always_comb begin
        p2_meta_next = p1_meta_reg;
        if (p1_meta_reg.cmd != rk4c_pkg::CMD_LOAD) begin
            p2_meta_next.start = start_rd_reg;
        end
        if (p1_meta_reg.cmd == rk4c_pkg::CMD_FINAL) begin
            op_next = slope_sum;
        end else begin
            op_next = k_ext;
        end
    end

    // h split at the binary point keeps each product narrow
    assign hhi_s    = $signed({1'b0, step_size[rk4c_pkg::STEP_W-1:rk4c_pkg::FRAC_W]});
    assign hlo_s    = $signed({1'b0, step_size[rk4c_pkg::FRAC_W-1:0]});
    assign phi_next = rk4c_pkg::PHI_W'(op_reg) * rk4c_pkg::PHI_W'(hhi_s);
    assign plo_next = rk4c_pkg::PLO_W'(op_reg) * rk4c_pkg::PLO_W'(hlo_s);

    // floor(op*h / 2^16), clipped where every stage saturates anyway
    assign scaled = rk4c_pkg::SCL_W'(phi_reg)
                  + rk4c_pkg::SCL_W'(plo_reg >>> rk4c_pkg::FRAC_W);

    always_comb begin
        if (scaled > rk4c_pkg::SCL_W'(rk4c_pkg::CLAMP_LIM)) begin
            c_next = rk4c_pkg::CLAMP_LIM;
        end else if (scaled < rk4c_pkg::SCL_W'(rk4c_pkg::CLAMP_NEG)) begin
            c_next = rk4c_pkg::CLAMP_NEG;
        end else begin
            c_next = rk4c_pkg::CLAMP_W'(scaled);
        end
    end

    // floor division by six of a negative value goes through (5 - c) / 6
    assign c_wide = (rk4c_pkg::CLAMP_W + 1)'(c_reg);
    assign mag    = c_reg[rk4c_pkg::CLAMP_W-1] ? (rk4c_pkg::DIV_BIAS - c_wide) : c_wide;

    always_comb begin
        div_tag_next.meta = p4_meta_reg;
        div_tag_next.neg  = c_reg[rk4c_pkg::CLAMP_W-1];
        case (p4_meta_reg.cmd)
            rk4c_pkg::CMD_HALF_A, rk4c_pkg::CMD_HALF_B: begin
                div_tag_next.delta_pre = c_reg >>> 1;
            end
            rk4c_pkg::CMD_FULL: begin
                div_tag_next.delta_pre = c_reg;
            end
            default: begin
                div_tag_next.delta_pre = '0;
            end
        endcase
    end

    rk4c_div6 u_div6 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p5_valid_reg),
        .in_word   (div_word_reg),
        .in_tag    (div_tag_reg),
        .out_valid (q_valid),
        .out_word  (q_word),
        .out_tag   (q_tag)
    );

    // final add and saturate
    assign q_s     = $signed({1'b0, q_word[rk4c_pkg::CLAMP_W-1:0]});
    assign start_x = rk4c_pkg::RES_W'(q_tag.meta.start);
    assign fin_sum = q_tag.neg ? (start_x - rk4c_pkg::RES_W'(q_s))
                               : (start_x + rk4c_pkg::RES_W'(q_s));
    assign pre_sum = start_x + rk4c_pkg::RES_W'(q_tag.delta_pre);
    assign total   = (q_tag.meta.cmd == rk4c_pkg::CMD_FINAL) ? fin_sum : pre_sum;

    always_comb begin
        if (total > rk4c_pkg::RES_W'(rk4c_pkg::DATA_MAX)) begin
            sat_value = rk4c_pkg::DATA_MAX;
        end else if (total < rk4c_pkg::RES_W'(rk4c_pkg::DATA_MIN)) begin
            sat_value = rk4c_pkg::DATA_MIN;
        end else begin
            sat_value = rk4c_pkg::DATA_W'(total);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= pop;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_meta_reg.cmd       <= head.cmd;
            p1_meta_reg.var_index <= head.var_index;
            p1_meta_reg.start     <= head.value_in;
            p1_k_reg              <= head.derivative;
            p2_meta_reg           <= p2_meta_next;
            op_reg                <= op_next;
            p3_meta_reg           <= p2_meta_reg;
            phi_reg               <= phi_next;
            plo_reg               <= plo_next;
            p4_meta_reg           <= p3_meta_reg;
            c_reg                 <= c_next;
            div_tag_reg           <= div_tag_next;
            div_word_reg          <= rk4c_pkg::DIV_W'(mag);
            out_data_reg.var_out   <= q_tag.meta.var_index;
            out_data_reg.new_value <= sat_value;
            out_data_reg.step_done <= (q_tag.meta.cmd == rk4c_pkg::CMD_FINAL);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_legal_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (head.cmd <= rk4c_pkg::CMD_FINAL))
        else $error("illegal stage code reached the back pipeline");

    a_stall_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("item left the queue while the output was stalled");

    a_dividend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p5_valid_reg |-> (div_word_reg <= rk4c_pkg::DIV_MAX))
        else $error("dividend beyond the clipped range");
`endif

endmodule

// File: design/rk4_stage_combiner.sv
// rk4_stage_combiner: stage bookkeeping of a fourth-order runge-kutta step
// throughput: one item per cycle while m_ready holds, set by the fully pipelined back end
// items with an illegal stage are dropped by the front register, no result
// reset: aresetn synchronous active low, clears handshake state, step_size to 1.0
// the per-variable stores have no reset and read undefined until written

module rk4_stage_combiner (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  rk4c_pkg::in_item_t           s_data,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output rk4c_pkg::out_item_t          m_data,
    // step size write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rk4c_pkg::STEP_W-1:0]  cfg_data
);

    // step size register, unsigned q15.16
    logic [rk4c_pkg::STEP_W-1:0] step_size_reg;

    // front to queue
    logic                 push_valid;
    logic                 push_ready;
    rk4c_pkg::in_item_t   push_item;

    // queue to back
    logic                 head_valid;
    logic                 head_ready;
    rk4c_pkg::in_item_t   head;

    // always taken; config writes must arrive only while the block is idle (unenforced)
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= rk4c_pkg::STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            step_size_reg <= cfg_data;
        end
    end

    // front: registers each item and drops stages above the final combine
    rk4c_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // small queue so a stalled output does not block the front at once
    rk4c_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head)
    );

    // back: store update at issue, then combine, multiply, divide, saturate
    // stores are written in item order at issue, so same-variable items
    // need no forwarding
    rk4c_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_size  (step_size_reg),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
